// File: hw/rtl/psc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the scale factor table of the pressure
// compensation core. No dependencies.
package psc_pkg;

	// Calibration block and field widths.
	localparam int CALIB_BYTES = 18;
	localparam int IDX_W       = 5;
	localparam int RAW_W       = 24;
	localparam int K_W         = 23;
	localparam int RATE_W      = 3;
	localparam int FRAC_W      = 32;     // fraction bits of Q8.32
	localparam int SCALED_W    = 40;     // Q8.32 scaled sample
	localparam int WIDE_W      = 64;     // Q40.24 polynomial terms
	localparam int Q_WIDE      = 24;     // fraction bits of Q40.24
	localparam int TEMP_SHIFT  = 15;     // c0/2 in Q16.16
	localparam int OUT_SHIFT   = 16;     // Q40.24 to Q24.8

	// Divider: quotient bits resolved per cycle.
	localparam int DIV_STEP  = 4;
	localparam int DIV_ITERS = SCALED_W / DIV_STEP;

	// Stream and register port widths.
	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 32;
	localparam int M_USER_W = 2;
	localparam int ADDR_W   = 3;
	localparam int APB_W    = 32;

	// Action codes on the input stream.
	localparam logic [S_USER_W-1:0] ACT_CAL   = 2'd0;
	localparam logic [S_USER_W-1:0] ACT_TEMP  = 2'd1;
	localparam logic [S_USER_W-1:0] ACT_PRESS = 2'd2;

	// Result kinds.
	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	// Register indexes, decoded from paddr[2].
	localparam logic REG_PRESS_RATE = 1'b0;
	localparam logic REG_TEMP_RATE  = 1'b1;

	// Operations carried from the front to the back.
	typedef enum logic [1:0] {
		OP_CAL,
		OP_TEMP,
		OP_PRESS
	} op_t;

	// One queue entry.
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
		logic [RAW_W-1:0] raw;
		logic [K_W-1:0]   k;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [RAW_W-1:0] raw;
		logic [K_W-1:0]   k;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [SCALED_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic                start;
		logic [WIDE_W-1:0]   a;
		logic [SCALED_W-1:0] b;
		logic                frac16;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WIDE_W-1:0] res;
	} mul_rsp_t;

	// Scale factor for an oversampling rate index.
	function automatic logic [K_W-1:0] scale_factor(input logic [RATE_W-1:0] rate);
		logic [K_W-1:0] k;
		unique case (rate)
			3'd0: k = 23'd524288;
			3'd1: k = 23'd1572864;
			3'd2: k = 23'd3670016;
			3'd3: k = 23'd7864320;
			3'd4: k = 23'd253952;
			3'd5: k = 23'd516096;
			3'd6: k = 23'd1040384;
			3'd7: k = 23'd2088960;
		endcase
		return k;
	endfunction

endpackage

// File: hw/rtl/psc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, drops the ones without effect, attaches
// the scale factor and queues the rest. Depends on psc_pkg.
module psc_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [psc_pkg::S_DATA_W-1:0]  s_tdata,  // byte_index, calib_byte, raw_sample
	input  logic [psc_pkg::S_USER_W-1:0]  s_tuser,  // action
	input  logic [psc_pkg::RATE_W-1:0]    press_rate,
	input  logic [psc_pkg::RATE_W-1:0]    temp_osr,
	output psc_pkg::entry_t               head,
	output logic                          head_valid,
	input  logic                          pop
);
	import psc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	entry_t           ent;
	logic             keep;
	logic             push;

	// Classify the incoming word.
	always_comb begin
		ent      = '0;
		ent.idx  = s_tdata[4:0];
		ent.data = s_tdata[12:5];
		ent.raw  = s_tdata[36:13];
		keep     = 1'b0;
		unique case (s_tuser)
			ACT_CAL: begin
				ent.op = OP_CAL;
				keep   = (ent.idx < IDX_W'(CALIB_BYTES));
			end
			ACT_TEMP: begin
				ent.op = OP_TEMP;
				ent.k  = scale_factor(temp_osr);
				keep   = 1'b1;
			end
			ACT_PRESS: begin
				ent.op = OP_PRESS;
				ent.k  = scale_factor(press_rate);
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign s_tready   = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push       = s_tvalid && s_tready && keep;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue popped while empty");

endmodule

// File: hw/rtl/psc_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider for sample scaling: raw * 2^32 / k, rounded
// half away from zero, several quotient bits a cycle. Depends on psc_pkg.
module psc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  psc_pkg::div_req_t req,
	output psc_pkg::div_rsp_t rsp
);
	import psc_pkg::*;

	localparam int REM_W = K_W + 1;
	localparam int NUM_W = RAW_W + FRAC_W;
	localparam int CNT_W = $clog2(DIV_ITERS + 1);

	logic                busy_q;
	logic                sign_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [REM_W-1:0]    rem_q;
	logic [SCALED_W-1:0] num_q;
	logic [SCALED_W-1:0] quo_q;
	logic [SCALED_W-1:0] res_q;
	logic [K_W-1:0]      k_q;
	logic                neg_q;
	logic [RAW_W-1:0]    raw_mag;
	logic [NUM_W-1:0]    num_init;
	logic [REM_W-1:0]    rem_nx;
	logic [SCALED_W-1:0] num_nx;
	logic [SCALED_W-1:0] quo_nx;

	// Numerator with the half divisor already added for rounding.
	always_comb begin
		raw_mag  = req.raw[RAW_W-1] ? (~req.raw + 1'b1) : req.raw;
		num_init = {raw_mag, FRAC_W'(req.k >> 1)};
	end

	// A few restoring steps per cycle.
	always_comb begin : div_steps
		logic [REM_W-1:0] r2;
		rem_nx = rem_q;
		num_nx = num_q;
		quo_nx = quo_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r2     = {rem_nx[REM_W-2:0], num_nx[SCALED_W-1]};
			num_nx = {num_nx[SCALED_W-2:0], 1'b0};
			if (r2 >= {1'b0, k_q}) begin
				rem_nx = r2 - {1'b0, k_q};
				quo_nx = {quo_nx[SCALED_W-2:0], 1'b1};
			end else begin
				rem_nx = r2;
				quo_nx = {quo_nx[SCALED_W-2:0], 1'b0};
			end
		end
	end

	// Control: iterate, then apply the sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && !busy_q && sign_q;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_ITERS - 1)) begin
					busy_q <= 1'b0;
					sign_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (sign_q) begin
				sign_q <= 1'b0;
			end
		end
	end

	// Datapath. The top numerator bits are below k since the quotient fits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= REM_W'(num_init[NUM_W-1:SCALED_W]);
			num_q <= num_init[SCALED_W-1:0];
			quo_q <= '0;
			k_q   <= req.k;
			neg_q <= req.raw[RAW_W-1];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			num_q <= num_nx;
			quo_q <= quo_nx;
		end
		if (sign_q) begin
			res_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = res_q;

endmodule

// File: hw/rtl/psc_mul.sv
`timescale 1ns / 1ps
// Sequential signed multiplier: four registered partial products, then a
// rounded shift by 16 or 32 on the magnitude and the sign. Depends on psc_pkg.
module psc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  psc_pkg::mul_req_t req,
	output psc_pkg::mul_rsp_t rsp
);
	import psc_pkg::*;

	localparam int AH     = WIDE_W / 2;
	localparam int BH     = SCALED_W / 2;
	localparam int PP_W   = AH + BH;
	localparam int PROD_W = WIDE_W + SCALED_W;
	localparam int N_PP   = 4;
	localparam int CNT_RND = N_PP + 1;
	localparam int CNT_SGN = N_PP + 2;
	localparam int CNT_W  = $clog2(CNT_SGN + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [WIDE_W-1:0]   a_q;
	logic [SCALED_W-1:0] b_q;
	logic                neg_q;
	logic                f16_q;
	logic [PP_W-1:0]     pp_s1;
	logic [1:0]          pp_sel_s1;
	logic                pp_vld_s1;
	logic [PROD_W-1:0]   acc_q;
	logic [WIDE_W-1:0]   mag_q;
	logic [WIDE_W-1:0]   res_q;
	logic [AH-1:0]       a_chunk;
	logic [BH-1:0]       b_chunk;
	logic [PROD_W-1:0]   pp_aligned;
	logic [PROD_W-1:0]   rnd_sum;

	// Operand chunks for the current partial product.
	always_comb begin
		a_chunk = cnt_q[1] ? a_q[WIDE_W-1:AH] : a_q[AH-1:0];
		b_chunk = cnt_q[0] ? b_q[SCALED_W-1:BH] : b_q[BH-1:0];
	end

	// Place the registered partial product.
	always_comb begin
		unique case (pp_sel_s1)
			2'd0: pp_aligned = PROD_W'(pp_s1);
			2'd1: pp_aligned = PROD_W'(pp_s1) << BH;
			2'd2: pp_aligned = PROD_W'(pp_s1) << AH;
			2'd3: pp_aligned = PROD_W'(pp_s1) << (AH + BH);
		endcase
	end

	assign rnd_sum = acc_q + (f16_q ? (PROD_W'(1) << (OUT_SHIFT - 1))
	                                : (PROD_W'(1) << (FRAC_W - 1)));

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
		end else begin
			done_q    <= !req.start && busy_q && (cnt_q == CNT_W'(CNT_SGN));
			pp_vld_s1 <= busy_q && (cnt_q < CNT_W'(N_PP));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(CNT_SGN)) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Magnitudes, partial products, accumulation, rounding and sign.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a[WIDE_W-1] ? (~req.a + 1'b1) : req.a;
			b_q   <= req.b[SCALED_W-1] ? (~req.b + 1'b1) : req.b;
			neg_q <= req.a[WIDE_W-1] ^ req.b[SCALED_W-1];
			f16_q <= req.frac16;
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + pp_aligned;
		end
		pp_s1     <= a_chunk * b_chunk;
		pp_sel_s1 <= cnt_q[1:0];
		if (busy_q && cnt_q == CNT_W'(CNT_RND)) begin
			mag_q <= f16_q ? rnd_sum[OUT_SHIFT +: WIDE_W] : rnd_sum[FRAC_W +: WIDE_W];
		end
		if (busy_q && cnt_q == CNT_W'(CNT_SGN)) begin
			res_q <= neg_q ? (~mag_q + 1'b1) : mag_q;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// File: hw/rtl/psc_back.sv
`timescale 1ns / 1ps
// Back end: calibration store, coefficient unpacking, the compensation
// sequencer and the output register. Depends on psc_pkg.
module psc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psc_pkg::entry_t               head,
	input  logic                          head_valid,
	output logic                          pop,
	output psc_pkg::div_req_t             div_req,
	input  psc_pkg::div_rsp_t             div_rsp,
	output psc_pkg::mul_req_t             mul_req,
	input  psc_pkg::mul_rsp_t             mul_rsp,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [psc_pkg::M_DATA_W-1:0]  m_tdata,  // value
	output logic [psc_pkg::M_USER_W-1:0]  m_tuser   // kind, saturated
);
	import psc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_ISSUE = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_RND   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// Which product is in flight, named after the term it feeds.
	typedef enum logic [2:0] {
		SP_TEMP,
		SP_C30,
		SP_T2,
		SP_T1,
		SP_C21,
		SP_U1,
		SP_UT
	} step_t;

	localparam logic [M_DATA_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
	localparam logic [M_DATA_W-1:0] OUT_MIN = 32'h8000_0000;

	state_t                     state_q;
	step_t                      step_q;
	logic [7:0]                 cal_q [CALIB_BYTES];
	logic signed [SCALED_W-1:0] ts_q;
	logic signed [SCALED_W-1:0] ps_q;
	logic signed [WIDE_W-1:0]   t_q;
	logic signed [WIDE_W-1:0]   p_q;
	logic                       kind_q;
	logic                       out_valid_q;
	logic [M_DATA_W-1:0]        out_value_q;
	logic                       out_kind_q;
	logic                       out_sat_q;

	logic signed [11:0]         c0, c1;
	logic signed [19:0]         c00, c10;
	logic signed [15:0]         c01, c11, c20, c21, c30;
	logic signed [WIDE_W-1:0]   prod;
	logic                       sat;
	logic [M_DATA_W-1:0]        sat_value;
	logic                       out_free;

	// Unpack the calibration bytes into signed coefficients.
	always_comb begin
		c0  = {cal_q[0], cal_q[1][7:4]};
		c1  = {cal_q[1][3:0], cal_q[2]};
		c00 = {cal_q[3], cal_q[4], cal_q[5][7:4]};
		c10 = {cal_q[5][3:0], cal_q[6], cal_q[7]};
		c01 = {cal_q[8], cal_q[9]};
		c11 = {cal_q[10], cal_q[11]};
		c20 = {cal_q[12], cal_q[13]};
		c21 = {cal_q[14], cal_q[15]};
		c30 = {cal_q[16], cal_q[17]};
	end

	assign prod     = $signed(mul_rsp.res);
	assign out_free = !out_valid_q || m_tready;

	// Requests to the queue, divider and multiplier.
	always_comb begin
		pop           = (state_q == ST_IDLE) && head_valid;
		div_req.start = pop && (head.op == OP_TEMP || head.op == OP_PRESS);
		div_req.raw   = head.raw;
		div_req.k     = head.k;
		mul_req.start  = (state_q == ST_ISSUE);
		mul_req.frac16 = (step_q == SP_TEMP);
		unique case (step_q)
			SP_TEMP: mul_req.a = WIDE_W'(c1);
			SP_C30:  mul_req.a = WIDE_W'(c30) <<< Q_WIDE;
			SP_C21:  mul_req.a = WIDE_W'(c21) <<< Q_WIDE;
			default: mul_req.a = t_q;
		endcase
		mul_req.b = (step_q == SP_TEMP || step_q == SP_UT) ? ts_q : ps_q;
	end

	// Clip to 32 bits.
	always_comb begin
		sat       = !((&p_q[WIDE_W-1:M_DATA_W-1]) || !(|p_q[WIDE_W-1:M_DATA_W-1]));
		sat_value = p_q[WIDE_W-1] ? OUT_MIN : OUT_MAX;
	end

	// Sequencer and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= SP_TEMP;
			ts_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CALIB_BYTES; i++) begin
				cal_q[i] <= '0;
			end
		end else begin
			// A new word takes the output register as the old one leaves.
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.op)
							OP_CAL:   cal_q[head.idx] <= head.data;
							OP_TEMP:  state_q <= ST_DIV;
							OP_PRESS: state_q <= ST_DIV;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (kind_q == KIND_TEMP) begin
							ts_q   <= $signed(div_rsp.quo);
							step_q <= SP_TEMP;
						end else begin
							step_q <= SP_C30;
						end
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_rsp.done) begin
						unique case (step_q)
							SP_TEMP: state_q <= ST_EMIT;
							SP_C30: begin
								step_q  <= SP_T2;
								state_q <= ST_ISSUE;
							end
							SP_T2: begin
								step_q  <= SP_T1;
								state_q <= ST_ISSUE;
							end
							SP_T1: begin
								step_q  <= SP_C21;
								state_q <= ST_ISSUE;
							end
							SP_C21: begin
								step_q  <= SP_U1;
								state_q <= ST_ISSUE;
							end
							SP_U1: begin
								step_q  <= SP_UT;
								state_q <= ST_ISSUE;
							end
							SP_UT:   state_q <= ST_RND;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RND: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Polynomial datapath and output payload.
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			kind_q <= (head.op == OP_TEMP) ? KIND_TEMP : KIND_PRESS;
		end
		if (state_q == ST_DIV && div_rsp.done && kind_q == KIND_PRESS) begin
			ps_q <= $signed(div_rsp.quo);
		end
		if (state_q == ST_MUL && mul_rsp.done) begin
			unique case (step_q)
				SP_TEMP: p_q <= (WIDE_W'(c0) <<< TEMP_SHIFT) + prod;
				SP_C30:  t_q <= (WIDE_W'(c20) <<< Q_WIDE) + prod;
				SP_T2:   t_q <= (WIDE_W'(c10) <<< Q_WIDE) + prod;
				SP_T1:   p_q <= (WIDE_W'(c00) <<< Q_WIDE) + prod;
				SP_C21:  t_q <= (WIDE_W'(c11) <<< Q_WIDE) + prod;
				SP_U1:   t_q <= (WIDE_W'(c01) <<< Q_WIDE) + prod;
				SP_UT:   p_q <= p_q + prod;
				default: p_q <= p_q;
			endcase
		end
		// Round half away from zero in one add: negative values take one less.
		if (state_q == ST_RND) begin
			p_q <= (p_q + (p_q[WIDE_W-1] ? WIDE_W'((1 << (OUT_SHIFT - 1)) - 1)
			                             : WIDE_W'(1 << (OUT_SHIFT - 1)))) >>> OUT_SHIFT;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_value_q <= sat ? sat_value : p_q[M_DATA_W-1:0];
			out_sat_q   <= sat;
			out_kind_q  <= kind_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = {out_sat_q, out_kind_q};

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");
	a_mul_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == ST_MUL)
		else $error("multiplier finished outside the multiply state");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_valid_q && !m_tready |=> state_q == ST_EMIT)
		else $error("pending result word would be overwritten");

endmodule

// File: hw/rtl/pressure_sensor_compensation_core.sv
`timescale 1ns / 1ps
// Top level of the pressure and temperature compensation core: register
// port, front end queue, back end sequencer and arithmetic units.
// Depends on psc_pkg, psc_front, psc_div, psc_mul and psc_back.
//
// Usage:
// - Input stream (s_*): each word is a calibration byte, a raw temperature
//   sample or a raw pressure sample, selected by s_tuser. Calibration bytes
//   load the 18-byte coefficient block and produce no output. Words with an
//   unknown action or a byte index past the block are dropped.
// - Output stream (m_*): one word per sample, temperature in Q16.16 degC or
//   pressure in Q24.8 Pa, with kind and a saturation flag in m_tuser.
// - Register port: rate index for pressure at 0x0, for temperature at 0x4.
//   Write only while no sample is in flight.
// In the back end a sample goes through the divider (4 quotient bits a
// cycle) and then the shared multiplier, one product for temperature and
// six for pressure. Samples are handled one at a time; the queue keeps
// accepting while it has room and the back end works. A stalled output
// holds its word and the back end waits only when its next result is
// ready. Reset clears the coefficients, the stored temperature, the rate
// registers and the queue.
module pressure_sensor_compensation_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Register port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psc_pkg::ADDR_W-1:0]    paddr,
	input  logic [psc_pkg::APB_W-1:0]     pwdata,
	output logic [psc_pkg::APB_W-1:0]     prdata,
	output logic                          pready,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [psc_pkg::S_DATA_W-1:0]  s_tdata,  // byte_index[4:0], calib_byte[12:5], raw_sample[36:13]
	input  logic [psc_pkg::S_USER_W-1:0]  s_tuser,  // action[1:0]
	// Output stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [psc_pkg::M_DATA_W-1:0]  m_tdata,  // value[31:0]
	output logic [psc_pkg::M_USER_W-1:0]  m_tuser   // kind[0], saturated[1]
);
	import psc_pkg::*;

	logic [RATE_W-1:0] press_rate_q;
	logic [RATE_W-1:0] temp_osr_q;
	logic              cfg_we;
	entry_t            head;
	logic              head_valid;
	logic              pop;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	mul_req_t          mul_req;
	mul_rsp_t          mul_rsp;

	// Register port: writes land in the access cycle.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = APB_W'((paddr[2] == REG_TEMP_RATE) ? temp_osr_q : press_rate_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_rate_q <= '0;
			temp_osr_q   <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_TEMP_RATE) begin
				temp_osr_q <= pwdata[RATE_W-1:0];
			end else begin
				press_rate_q <= pwdata[RATE_W-1:0];
			end
		end
	end

	psc_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.press_rate (press_rate_q),
		.temp_osr   (temp_osr_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	psc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	psc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	psc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pressure_sensor_compensation_core: drives calibration
// bytes and raw samples over the input stream, and checks each output word against a
// built-in model of the compensation math. Depends on psc_pkg and the core RTL.
module tb;
	import psc_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 400;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 68;

	localparam logic [S_USER_W-1:0] ACT_NONE = 2'd3;
	localparam logic [ADDR_W-1:0]   ADDR_PRESS_RATE = 3'h0;
	localparam logic [ADDR_W-1:0]   ADDR_TEMP_RATE  = 3'h4;

	localparam logic [RAW_W-1:0] RAW_MAX = 24'h7F_FFFF;
	localparam logic [RAW_W-1:0] RAW_MIN = 24'h80_0000;

	// Divisors for each oversampling rate index.
	localparam longint RATE_DIVISOR [8] = '{
		524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
	};
	localparam longint Q24_ONE   = longint'(1) << Q_WIDE;
	localparam longint VALUE_MAX = (longint'(1) << 31) - 1;
	localparam longint VALUE_MIN = -(longint'(1) << 31);

	// One compensated reading as it leaves the core.
	typedef struct packed {
		logic        sat;
		logic        kind;
		logic [31:0] value;
	} reading_t;

	// Tracks calibration, rates and stored temperature, and the readings still owed.
	class compensation_scoreboard;
		logic [7:0] calib_bytes [CALIB_BYTES];
		longint     temp_q32;
		logic [2:0] press_rate;
		logic [2:0] temp_osr;
		reading_t   pending_readings [$];
		int         errors;

		function new();
			foreach (calib_bytes[i])
				calib_bytes[i] = 8'h00;
			temp_q32   = 0;
			press_rate = '0;
			temp_osr   = '0;
			errors     = 0;
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction

		function void set_rate(logic reg_sel, logic [31:0] data);
			if (reg_sel == REG_PRESS_RATE) begin
				press_rate = data[2:0];
			end else begin
				temp_osr = data[2:0];
			end
		endfunction

		function longint sext_bits(longint unsigned v, int w);
			longint s;
			s = v << (64 - w);
			return s >>> (64 - w);
		endfunction

		// Raw sample times 2^32 over the divisor, rounded half away from zero.
		function longint scale_sample(longint raw, longint k);
			longint unsigned num;
			num = (raw < 0) ? -raw : raw;
			num = ((num << 32) + (k >> 1)) / k;
			return (raw < 0) ? -$signed(num) : $signed(num);
		endfunction

		// Exact product of two values, divided by 2^32 and rounded half away from zero.
		function longint product_q32(longint a, longint b);
			longint unsigned ua, ub;
			logic [127:0]    prod;
			ua = (a < 0) ? -a : a;
			ub = (b < 0) ? -b : b;
			prod = {64'd0, ua} * {64'd0, ub} + 128'h8000_0000;
			return ((a < 0) != (b < 0)) ? -$signed(prod[95:32]) : $signed(prod[95:32]);
		endfunction

		function longint round_off(longint x, int n);
			longint unsigned m;
			m = (x < 0) ? -x : x;
			m = (m + (64'd1 << (n - 1))) >> n;
			return (x < 0) ? -$signed(m) : $signed(m);
		endfunction

		function void owe_reading(logic kind, longint v);
			reading_t r;
			r.kind = kind;
			r.sat  = 1'b0;
			if (v > VALUE_MAX) begin
				v     = VALUE_MAX;
				r.sat = 1'b1;
			end
			if (v < VALUE_MIN) begin
				v     = VALUE_MIN;
				r.sat = 1'b1;
			end
			r.value = v[31:0];
			pending_readings.push_back(r);
		endfunction

		// Applies one accepted input word and records the reading it causes, if any.
		function void note_word(logic [1:0] act, logic [4:0] idx, logic [7:0] cbyte,
				logic [23:0] raw_bits);
			longint raw, c0, c1, c00, c10, c01, c11, c20, c21, c30, ps, acc, tc, p;
			raw = sext_bits(raw_bits, RAW_W);
			case (act)
				ACT_CAL: begin
					if (idx < CALIB_BYTES)
						calib_bytes[idx] = cbyte;
				end
				ACT_TEMP: begin
					c0 = sext_bits({calib_bytes[0], calib_bytes[1][7:4]}, 12);
					c1 = sext_bits({calib_bytes[1][3:0], calib_bytes[2]}, 12);
					temp_q32 = scale_sample(raw, RATE_DIVISOR[temp_osr]);
					owe_reading(KIND_TEMP, c0 * (longint'(1) << TEMP_SHIFT)
						+ round_off(c1 * temp_q32, OUT_SHIFT));
				end
				ACT_PRESS: begin
					c00 = sext_bits({calib_bytes[3], calib_bytes[4], calib_bytes[5][7:4]}, 20);
					c10 = sext_bits({calib_bytes[5][3:0], calib_bytes[6], calib_bytes[7]}, 20);
					c01 = sext_bits({calib_bytes[8], calib_bytes[9]}, 16);
					c11 = sext_bits({calib_bytes[10], calib_bytes[11]}, 16);
					c20 = sext_bits({calib_bytes[12], calib_bytes[13]}, 16);
					c21 = sext_bits({calib_bytes[14], calib_bytes[15]}, 16);
					c30 = sext_bits({calib_bytes[16], calib_bytes[17]}, 16);
					ps  = scale_sample(raw, RATE_DIVISOR[press_rate]);
					// Horner form in Q40.24, pressure terms first, then the temperature terms.
					acc = c20 * Q24_ONE + product_q32(c30 * Q24_ONE, ps);
					acc = c10 * Q24_ONE + product_q32(acc, ps);
					p   = c00 * Q24_ONE + product_q32(acc, ps);
					tc  = c11 * Q24_ONE + product_q32(c21 * Q24_ONE, ps);
					tc  = c01 * Q24_ONE + product_q32(tc, ps);
					p   = p + product_q32(tc, temp_q32);
					owe_reading(KIND_PRESS, round_off(p, OUT_SHIFT));
				end
				default: begin
				end
			endcase
		endfunction

		// Compares one output word with the oldest reading owed.
		function void check_reading(logic [1:0] user, logic [31:0] data);
			reading_t want;
			if (pending_readings.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual value %0d kind %0d sat %0d",
					$time, $signed(data), user[0], user[1]);
				return;
			end
			want = pending_readings.pop_front();
			if (user[0] !== want.kind) begin
				errors++;
				$display("%0t: kind mismatch, expected %0d, actual %0d",
					$time, want.kind, user[0]);
			end
			if (data !== want.value) begin
				errors++;
				$display("%0t: value mismatch, expected %0d, actual %0d",
					$time, $signed(want.value), $signed(data));
			end
			if (user[1] !== want.sat) begin
				errors++;
				$display("%0t: saturation flag mismatch, expected %0d, actual %0d",
					$time, want.sat, user[1]);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [APB_W-1:0]    pwdata;
	logic [APB_W-1:0]    prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;  // byte_index[4:0], calib_byte[12:5], raw_sample[36:13]
	logic [S_USER_W-1:0] s_tuser;  // action[1:0]
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;  // value[31:0]
	logic [M_USER_W-1:0] m_tuser;  // kind[0], saturated[1]

	compensation_scoreboard sb = new();

	int burst_left   = 0;
	bit gaps_on      = 1'b1;
	bit hold_request = 1'b0;

	pressure_sensor_compensation_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Both streams are sampled at the rising edge.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_word(s_tuser, s_tdata[4:0], s_tdata[12:5], s_tdata[36:13]);
		if (m_tvalid && m_tready)
			sb.check_reading(m_tuser, m_tdata);
	end

	// Ends the run when nothing moves on any port for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (psel && penable && pwrite)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("TB_ERROR");
		$finish;
	end

	// Output back-pressure: spans of one pattern each, and one long hold-off on request.
	initial begin : receiver
		int mode;
		int span;
		m_tready = 1'b0;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		logic [7:0] corner [4];
		corner = '{8'h00, 8'hFF, 8'h80, 8'h7F};
		if ($urandom_range(0, 3) == 0)
			return corner[$urandom_range(0, 3)];
		return 8'($urandom);
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		logic [RAW_W-1:0] corner [6];
		corner = '{RAW_MAX, RAW_MIN, 24'h00_0000, 24'hFF_FFFF, 24'h00_0001, 24'h7F_0000};
		if ($urandom_range(0, 4) == 0)
			return corner[$urandom_range(0, 5)];
		return RAW_W'($urandom);
	endfunction

	// Offers a word; once a burst ran out, opens a new one after a random gap if gaps_on.
	task automatic send_word(input logic [1:0] act, input logic [4:0] idx,
			input logic [7:0] cbyte, input logic [RAW_W-1:0] raw);
		int idle;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle = gaps_on ? $urandom_range(1, 15) : 0;
			if (idle > 0) begin
				s_tvalid <= 1'b0;
				repeat (idle) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, raw, cbyte, idx};
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stops sending and waits until every reading owed has come out.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_rate(addr[2], data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Corner cases at the reset rates, including pressure before any temperature.
	task automatic run_directed();
		send_word(ACT_CAL, 5'd0, 8'h80, RAW_MAX);
		send_word(ACT_CAL, 5'd1, 8'h00, RAW_MIN);
		send_word(ACT_CAL, 5'd2, 8'hFF, 24'h0);
		send_word(ACT_CAL, 5'd3, 8'h7F, 24'h0);
		send_word(ACT_CAL, 5'd16, 8'h7F, 24'h0);
		send_word(ACT_CAL, 5'd17, 8'hFF, 24'h0);
		send_word(ACT_CAL, 5'd18, 8'hAA, 24'h0);
		send_word(ACT_CAL, 5'd31, 8'h55, 24'h0);
		send_word(ACT_NONE, 5'd31, 8'hFF, RAW_MAX);
		send_word(ACT_PRESS, 5'd0, 8'h00, RAW_MAX);
		send_word(ACT_PRESS, 5'd0, 8'h00, RAW_MIN);
		send_word(ACT_PRESS, 5'd0, 8'h00, 24'h0);
		send_word(ACT_TEMP, 5'd0, 8'h00, 24'h0);
		send_word(ACT_TEMP, 5'd0, 8'h00, RAW_MAX);
		send_word(ACT_TEMP, 5'd0, 8'h00, RAW_MIN);
		send_word(ACT_TEMP, 5'd0, 8'h00, 24'hFF_FFFF);
		send_word(ACT_PRESS, 5'd0, 8'h00, 24'h00_0001);
		send_word(ACT_PRESS, 5'd0, 8'h00, 24'hFF_FFFF);
		send_word(ACT_TEMP, 5'd0, 8'h00, RAW_MAX);
		send_word(ACT_PRESS, 5'd0, 8'h00, RAW_MAX);
		send_word(ACT_PRESS, 5'd0, 8'h00, RAW_MIN);
		send_word(ACT_CAL, 5'd17, 8'h00, 24'h0);
		send_word(ACT_PRESS, 5'd0, 8'h00, RAW_MAX);
	endtask

	// Mostly samples on random calibration, with full reloads, stray bytes and bad actions.
	task automatic run_random(input int count);
		int         done_items;
		int         pick;
		logic [4:0] idx;
		done_items = 0;
		while (done_items < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				for (int i = 0; i < CALIB_BYTES; i++)
					send_word(ACT_CAL, 5'(i), pick_byte(), RAW_W'($urandom));
				done_items += CALIB_BYTES;
			end else if (pick < 16) begin
				idx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(CALIB_BYTES, 31))
					: 5'($urandom_range(0, CALIB_BYTES - 1));
				send_word(ACT_CAL, idx, pick_byte(), RAW_W'($urandom));
				if (idx < CALIB_BYTES)
					done_items++;
			end else if (pick < 19) begin
				send_word(ACT_NONE, 5'($urandom), 8'($urandom), RAW_W'($urandom));
			end else if (pick < 50) begin
				send_word(ACT_TEMP, 5'($urandom), 8'($urandom), pick_raw());
				done_items++;
			end else begin
				send_word(ACT_PRESS, 5'($urandom), 8'($urandom), pick_raw());
				done_items++;
			end
		end
	endtask

	initial begin : stimulus
		logic [2:0] press_sel [5];
		logic [2:0] temp_sel  [5];
		logic [2:0] pr, tr;
		// Rate pairs for the first phases: both extremes of the index and of the divisor.
		press_sel = '{3'd0, 3'd7, 3'd4, 3'd3, 3'd0};
		temp_sel  = '{3'd0, 3'd7, 3'd3, 3'd4, 3'd0};
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_CAL;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			if (phase > 0) begin
				pr = (phase < 5) ? press_sel[phase] : 3'($urandom);
				tr = (phase < 5) ? temp_sel[phase] : 3'($urandom);
				write_reg(ADDR_PRESS_RATE, ($urandom & ~32'h7) | pr);
				write_reg(ADDR_TEMP_RATE, ($urandom & ~32'h7) | tr);
			end
			gaps_on = (phase % 3 != 1);
			// One phase holds the output off long enough to back the input up.
			if (phase == 5)
				hold_request = 1'b1;
			run_random(PHASE_ITEMS);
		end
		wait_idle();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
